// ===== sv/arpre_pkg.sv =====
// Shared types and constants of the ARP resolution engine.
package arpre_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int RIW = $clog2(MAX_RESULTS);
  localparam int RCW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_SEND = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [1:0] CFG_LIFETIME = 2'd2;
  localparam logic [1:0] CFG_RETRY    = 2'd3;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ARP_REQ   = 16'd1;
  localparam logic [15:0] ARP_RESP  = 16'd2;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [15:0] tag;
    logic [31:0] ip;
  } res_t;

  typedef struct packed {
    logic clr;
    logic push;
    logic drain;
  } rb_ctl_t;

endpackage

// ===== sv/arpre_rbuf.sv =====
// Result buffer: collects the beats of one item and drains them with a last flag.
module arpre_rbuf import arpre_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rb_ctl_t        ctl_i,
  input  res_t           ent_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output res_t           ent_o,
  output logic           last_o,
  output logic           done_o,
  output logic [RCW-1:0] cnt_o
);

  res_t           buf_q [MAX_RESULTS];
  logic [RCW-1:0] cnt_q;
  logic [RIW-1:0] rd_q;
  logic           wr_en;

  assign wr_en       = ctl_i.push && (cnt_q < RCW'(MAX_RESULTS));
  assign out_valid_o = ctl_i.drain;
  assign ent_o       = buf_q[rd_q];
  assign last_o      = (rd_q == RIW'(cnt_q - 1'b1));
  assign done_o      = ctl_i.drain && out_ready_i && last_o;
  assign cnt_o       = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (ctl_i.clr || done_o) begin
      cnt_q <= (ctl_i.clr && wr_en) ? RCW'(1) : '0;
      rd_q  <= '0;
    end else begin
      if (wr_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctl_i.drain && out_ready_i) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      buf_q[cnt_q[RIW-1:0]] <= ent_i;
    end
  end

endmodule

// ===== sv/arp_resolution_engine.sv =====
// ARP resolution engine top level: cache, pending table, tag queues and sequencer.
//
// One item is taken at a time. A send or ARP frame walks the cache and the
// pending table together, one entry of each per cycle, through one address
// compare and one 64-bit age subtractor per table, then acts in S_ACT.
// A tick first updates the clock in S_TIME and then walks the tables.
// An ARP reply that flushes a queue reads each queued tag on the tag memory
// port and pushes it as a result, then closes in S_FRD. Results then leave
// one beat per cycle while out_ready_i is high; an IPv4 frame or a dropped
// frame needs no walk.
module arp_resolution_engine import arpre_pkg::*; #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int PENDING_ENTRIES = 8,
  parameter int QUEUE_DEPTH     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] next_hop_ip_i,
  input  logic [15:0] dgram_tag_i,
  input  logic [47:0] frame_dst_mac_i,
  input  logic [15:0] frame_ethertype_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [47:0] arp_sender_mac_i,
  input  logic [31:0] arp_sender_ip_i,
  input  logic [31:0] arp_target_ip_i,
  input  logic [31:0] elapsed_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [47:0] dest_mac_o,
  output logic [15:0] out_tag_o,
  output logic [31:0] arp_ip_o,
  output logic        last_o
);

  localparam int CIW    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PIW    = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SCAN_N = (CACHE_ENTRIES > PENDING_ENTRIES) ? CACHE_ENTRIES : PENDING_ENTRIES;
  localparam int SW     = $clog2(SCAN_N + 1);
  localparam int TAGS   = PENDING_ENTRIES * QUEUE_DEPTH;
  localparam int TAW    = (TAGS > 1) ? $clog2(TAGS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TIME  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_ACT   = 7'b0001000,
    S_FRD   = 7'b0010000,
    S_FWR   = 7'b0100000,
    S_DRAIN = 7'b1000000
  } state_e;

  state_e state_q;

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q, life_q, retry_q;
  logic [63:0] now_q;

  logic [CACHE_ENTRIES-1:0] cache_valid_q;
  logic [31:0] cache_ip_q    [CACHE_ENTRIES];
  logic [47:0] cache_mac_q   [CACHE_ENTRIES];
  logic [63:0] cache_stamp_q [CACHE_ENTRIES];

  logic [PENDING_ENTRIES-1:0] pend_valid_q;
  logic [31:0]  pend_ip_q    [PENDING_ENTRIES];
  logic [63:0]  pend_stamp_q [PENDING_ENTRIES];
  logic [QCW-1:0] pend_cnt_q [PENDING_ENTRIES];
  logic [15:0]  tag_mem [TAGS];
  logic [15:0]  tag_rd_q;

  logic [1:0]  op_q;
  logic [31:0] hop_q, sip_q, tip_q, elapsed_q;
  logic [15:0] tag_q, opc_q;
  logic [47:0] smac_q, chit_mac_q;

  logic [SW-1:0]  scan_q;
  logic [QCW-1:0] j_q, pcnt_q;
  logic           chit_q, cfree_q, phit_q, pfree_q;
  logic [CIW-1:0] chit_idx_q, cfree_idx_q, old_idx_q, slot;
  logic [PIW-1:0] phit_idx_q, pfree_idx_q;
  logic [63:0]    best_q;

  logic [CIW-1:0] ci;
  logic [PIW-1:0] pi;
  logic           in_c, in_p, accept, addr_ok, walk, last_scan;
  logic [31:0]    key;
  logic [63:0]    c_age, p_age;
  logic c_hit_now, c_free_now, c_old_now, c_exp_now;
  logic p_hit_now, p_free_now, retry_fire;
  logic learn_en, learn_new, q_add, p_new, fl_rd, fl_end;
  logic mem_we;
  logic [TAW-1:0] mem_waddr, mem_raddr;

  rb_ctl_t        rb_ctl;
  res_t           rb_ent, rb_out;
  logic           rb_done, rb_full;
  logic [RCW-1:0] rb_cnt;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign addr_ok    = (frame_dst_mac_i == own_mac_q) || (frame_dst_mac_i == BCAST_MAC);
  assign rb_full    = (rb_cnt == RCW'(MAX_RESULTS));

  assign ci        = scan_q[CIW-1:0];
  assign pi        = scan_q[PIW-1:0];
  assign in_c      = scan_q < SW'(CACHE_ENTRIES);
  assign in_p      = scan_q < SW'(PENDING_ENTRIES);
  assign last_scan = scan_q == SW'(SCAN_N - 1);
  assign key       = (op_q == OP_SEND) ? hop_q : sip_q;
  assign c_age     = now_q - cache_stamp_q[ci];
  assign p_age     = now_q - pend_stamp_q[pi];
  assign walk      = (state_q == S_SCAN) && (op_q != OP_TICK);

  assign c_hit_now  = walk && in_c && cache_valid_q[ci] && (cache_ip_q[ci] == key) && !chit_q;
  assign c_free_now = walk && in_c && !cache_valid_q[ci] && !cfree_q;
  assign c_old_now  = walk && in_c && ((ci == '0) || (c_age > best_q));
  assign c_exp_now  = (state_q == S_SCAN) && (op_q == OP_TICK) && in_c && cache_valid_q[ci]
                      && (c_age >= {32'b0, life_q});
  assign p_hit_now  = walk && in_p && pend_valid_q[pi] && (pend_ip_q[pi] == key) && !phit_q;
  assign p_free_now = walk && in_p && !pend_valid_q[pi] && !pfree_q;
  assign retry_fire = (state_q == S_SCAN) && (op_q == OP_TICK) && in_p && pend_valid_q[pi]
                      && (p_age >= {32'b0, retry_q}) && !rb_full;

  assign learn_en  = (state_q == S_ACT) && (op_q == OP_RECV);
  assign learn_new = learn_en && !chit_q;
  assign slot      = cfree_q ? cfree_idx_q : old_idx_q;
  assign q_add     = (state_q == S_ACT) && (op_q == OP_SEND) && !chit_q && phit_q
                     && (pcnt_q < QCW'(QUEUE_DEPTH));
  assign p_new     = (state_q == S_ACT) && (op_q == OP_SEND) && !chit_q && !phit_q && pfree_q;
  assign fl_rd     = (state_q == S_FRD) && (j_q < pcnt_q) && !rb_full;
  assign fl_end    = (state_q == S_FRD) && !fl_rd;

  assign mem_we    = q_add || p_new;
  assign mem_waddr = q_add ? TAW'(int'(phit_idx_q) * QUEUE_DEPTH + int'(pcnt_q))
                           : TAW'(int'(pfree_idx_q) * QUEUE_DEPTH);
  assign mem_raddr = TAW'(int'(phit_idx_q) * QUEUE_DEPTH + int'(j_q));

  always_comb begin
    rb_ctl.clr   = accept;
    rb_ctl.push  = 1'b0;
    rb_ctl.drain = (state_q == S_DRAIN);
    rb_ent       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (operation_i == OP_RECV) && addr_ok && (frame_ethertype_i == ETH_IPV4)) begin
          rb_ctl.push = 1'b1;
          rb_ent      = '{kind: KIND_DELIVER, mac: '0, tag: dgram_tag_i, ip: '0};
        end
      end
      S_SCAN: begin
        if (retry_fire) begin
          rb_ctl.push = 1'b1;
          rb_ent      = '{kind: KIND_REQUEST, mac: BCAST_MAC, tag: '0, ip: pend_ip_q[pi]};
        end
      end
      S_ACT: begin
        if ((op_q == OP_SEND) && chit_q) begin
          rb_ctl.push = 1'b1;
          rb_ent      = '{kind: KIND_SEND, mac: chit_mac_q, tag: tag_q, ip: '0};
        end else if (p_new) begin
          rb_ctl.push = 1'b1;
          rb_ent      = '{kind: KIND_REQUEST, mac: BCAST_MAC, tag: '0, ip: hop_q};
        end else if (learn_en && (opc_q == ARP_REQ) && (tip_q == own_ip_q)) begin
          rb_ctl.push = 1'b1;
          rb_ent      = '{kind: KIND_REPLY, mac: smac_q, tag: '0, ip: sip_q};
        end
      end
      S_FWR: begin
        rb_ctl.push = 1'b1;
        rb_ent      = '{kind: KIND_SEND, mac: smac_q, tag: tag_rd_q, ip: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      own_mac_q     <= '0;
      own_ip_q      <= '0;
      life_q        <= 32'd30000;
      retry_q       <= 32'd5000;
      now_q         <= '0;
      cache_valid_q <= '0;
      pend_valid_q  <= '0;
      for (int k = 0; k < PENDING_ENTRIES; k++) pend_cnt_q[k] <= '0;
      scan_q        <= '0;
      j_q           <= '0;
      chit_q        <= 1'b0;
      cfree_q       <= 1'b0;
      phit_q        <= 1'b0;
      pfree_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_OWN_MAC:  own_mac_q <= cfg_data_i;
          CFG_OWN_IP:   own_ip_q  <= cfg_data_i[31:0];
          CFG_LIFETIME: life_q    <= cfg_data_i[31:0];
          CFG_RETRY:    retry_q   <= cfg_data_i[31:0];
        endcase
      end
      if (c_hit_now)  chit_q  <= 1'b1;
      if (c_free_now) cfree_q <= 1'b1;
      if (p_hit_now)  phit_q  <= 1'b1;
      if (p_free_now) pfree_q <= 1'b1;
      if (c_exp_now)  cache_valid_q[ci] <= 1'b0;
      if (learn_new)  cache_valid_q[slot] <= 1'b1;
      if (q_add)      pend_cnt_q[phit_idx_q] <= pcnt_q + 1'b1;
      if (p_new) begin
        pend_valid_q[pfree_idx_q] <= 1'b1;
        pend_cnt_q[pfree_idx_q]   <= QCW'(1);
      end
      if (fl_end) begin
        pend_valid_q[phit_idx_q] <= 1'b0;
        pend_cnt_q[phit_idx_q]   <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            scan_q  <= '0;
            j_q     <= '0;
            chit_q  <= 1'b0;
            cfree_q <= 1'b0;
            phit_q  <= 1'b0;
            pfree_q <= 1'b0;
            unique case (operation_i)
              OP_SEND: state_q <= S_SCAN;
              OP_RECV: begin
                if (addr_ok && (frame_ethertype_i == ETH_IPV4)) begin
                  state_q <= S_DRAIN;
                end else if (addr_ok && (frame_ethertype_i == ETH_ARP)) begin
                  state_q <= S_SCAN;
                end
              end
              OP_TICK: state_q <= S_TIME;
              default: ;
            endcase
          end
        end
        S_TIME: begin
          now_q   <= now_q + {32'b0, elapsed_q};
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (last_scan) state_q <= S_ACT;
        end
        S_ACT: begin
          if ((op_q == OP_RECV) && (opc_q == ARP_RESP) && phit_q) begin
            state_q <= S_FRD;
          end else if ((rb_cnt != '0) || rb_ctl.push) begin
            state_q <= S_DRAIN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FRD: begin
          if (fl_rd) begin
            state_q <= S_FWR;
          end else if (rb_cnt != '0) begin
            state_q <= S_DRAIN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FWR: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_FRD;
        end
        S_DRAIN: begin
          if (rb_done) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= operation_i;
      hop_q     <= next_hop_ip_i;
      tag_q     <= dgram_tag_i;
      opc_q     <= arp_opcode_i;
      smac_q    <= arp_sender_mac_i;
      sip_q     <= arp_sender_ip_i;
      tip_q     <= arp_target_ip_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (c_hit_now) begin
      chit_idx_q <= ci;
      chit_mac_q <= cache_mac_q[ci];
    end
    if (c_free_now) cfree_idx_q <= ci;
    if (c_old_now) begin
      best_q    <= c_age;
      old_idx_q <= ci;
    end
    if (p_hit_now) begin
      phit_idx_q <= pi;
      pcnt_q     <= pend_cnt_q[pi];
    end
    if (p_free_now) pfree_idx_q <= pi;
    if (learn_en) begin
      if (chit_q) begin
        cache_stamp_q[chit_idx_q] <= now_q;
      end else begin
        cache_ip_q[slot]    <= sip_q;
        cache_mac_q[slot]   <= smac_q;
        cache_stamp_q[slot] <= now_q;
      end
    end
    if (p_new) begin
      pend_ip_q[pfree_idx_q]    <= hop_q;
      pend_stamp_q[pfree_idx_q] <= now_q;
    end
    if (retry_fire) pend_stamp_q[pi] <= now_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tag_mem[mem_waddr] <= tag_q;
    if (fl_rd)  tag_rd_q <= tag_mem[mem_raddr];
  end

  arpre_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (rb_ctl),
    .ent_i       (rb_ent),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .ent_o       (rb_out),
    .last_o      (last_o),
    .done_o      (rb_done),
    .cnt_o       (rb_cnt)
  );

  assign result_kind_o = rb_out.kind;
  assign dest_mac_o    = rb_out.mac;
  assign out_tag_o     = rb_out.tag;
  assign arp_ip_o      = rb_out.ip;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_SEND)) |=> !in_ready_o)
    else $error("engine ready right after taking a beat");
  a_drain_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rb_cnt != '0)) else $error("output beat with empty result buffer");
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rb_cnt <= RCW'(MAX_RESULTS)) else $error("result count above limit");
  a_flush_in_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWR) |-> (j_q < pcnt_q)) else $error("flush read past queue fill");
`endif

endmodule
